FILE: sv/dqs_pkg.sv
// Shared package of the double-ended queue with search.
// Holds opcode and status codes, field widths and controller/datapath structs.
// No dependencies.
package dqs_pkg;

  localparam int DQS_CAPACITY = 16;
  localparam int DATA_W       = 32;
  localparam int OP_W         = 3;
  localparam int ST_W         = 3;
  localparam int POS_W        = 5;

  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_SEARCH     = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd1;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_MATCH     = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;    // transfer of a new command this cycle
    logic pop_emit;  // pop read data is valid, emit it
    logic scan;      // compare one held entry with the key
    logic flush;     // search finished, emit the final result
  } dqs_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic scan_last;
  } dqs_stat_t;

endpackage

FILE: sv/double_ended_queue_with_search.sv
// Top level of the double-ended queue with search.
// Instantiates dqs_ctrl and dqs_datapath; depends on dqs_pkg.
//
//  channel  | handshake              | payload
//  ---------+------------------------+------------------------------------------
//  command  | start_i / busy_o       | opcode_i, item_value_i
//  result   | result_strobe_o        | status_o, result_value_o, position_o, last_o
//
// A push, a refused push, a pop of an empty queue and a search of an empty
// queue give their result in the cycle after the transfer; busy_o never rises.
// A pop is read out through the slot memory's one registered read port, then
// emitted from the pop state. A search scans one held entry per cycle through
// that port; each match leaves in the cycle after the next match is seen, and
// the final result is registered out of the flush state after the scan ends.
// Opcodes 5..7 are dropped without a result.
// Reset clears front index, count and control; the slot memory is not cleared.
// The receiver cannot stall: every result stands for exactly one cycle.
module double_ended_queue_with_search #(
  parameter int CAPACITY = dqs_pkg::DQS_CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic [dqs_pkg::OP_W-1:0]           opcode_i,
  input  logic signed [dqs_pkg::DATA_W-1:0]  item_value_i,
  output logic                               result_strobe_o,
  output logic [dqs_pkg::ST_W-1:0]           status_o,
  output logic signed [dqs_pkg::DATA_W-1:0]  result_value_o,
  output logic [dqs_pkg::POS_W-1:0]          position_o,
  output logic                               last_o
);
  import dqs_pkg::*;

  dqs_cmd_t  cmd;
  dqs_stat_t stat;

  // Sequence each command: transfer, pop readout, scan steps, final flush.
  dqs_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .opcode_i (opcode_i),
    .stat_i   (stat),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  // Hold the ring and drive the registered result ports.
  dqs_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .opcode_i        (opcode_i),
    .item_value_i    (item_value_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .result_strobe_o (result_strobe_o),
    .status_o        (status_o),
    .result_value_o  (result_value_o),
    .position_o      (position_o),
    .last_o          (last_o)
  );

  // A non-final match always comes out while the search is still running.
  a_nonlast_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_o) |-> busy_o)
    else $error("non-final result outside a search");

  // Only a search emits non-final results, and only as matches.
  a_nonlast_match : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_o) |-> (status_o == ST_MATCH))
    else $error("non-final result that is not a match");

endmodule

FILE: sv/dqs_ctrl.sv
// Controller state machine of the double-ended queue with search.
// Depends on dqs_pkg for opcodes and command/status structs.
module dqs_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [dqs_pkg::OP_W-1:0]  opcode_i,
  input  dqs_pkg::dqs_stat_t        stat_i,
  output dqs_pkg::dqs_cmd_t         cmd_o,
  output logic                      busy_o
);
  import dqs_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_POP   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  logic        is_pop;

  assign is_pop = (opcode_i == OP_POP_FRONT) || (opcode_i == OP_POP_BACK);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (start_i && !stat_i.empty) begin
          if (is_pop) begin
            state_d = S_POP;
          end else if (opcode_i == OP_SEARCH) begin
            state_d = S_SCAN;
          end
        end
      end
      S_POP:   state_d = S_IDLE;
      S_SCAN: begin
        if (stat_i.scan_last) begin
          state_d = S_FLUSH;
        end
      end
      S_FLUSH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o         = (state_q != S_IDLE);
  assign cmd_o.accept   = (state_q == S_IDLE) && start_i;
  assign cmd_o.pop_emit = (state_q == S_POP);
  assign cmd_o.scan     = (state_q == S_SCAN);
  assign cmd_o.flush    = (state_q == S_FLUSH);

endmodule

FILE: sv/dqs_datapath.sv
// Datapath of the double-ended queue with search: slot memory, ring
// pointers, scan offset, pending match and result registers. Depends on dqs_pkg.
module dqs_datapath #(
  parameter int CAPACITY = dqs_pkg::DQS_CAPACITY
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [dqs_pkg::OP_W-1:0]           opcode_i,
  input  logic signed [dqs_pkg::DATA_W-1:0]  item_value_i,
  input  dqs_pkg::dqs_cmd_t                  cmd_i,
  output dqs_pkg::dqs_stat_t                 stat_o,
  output logic                               result_strobe_o,
  output logic [dqs_pkg::ST_W-1:0]           status_o,
  output logic signed [dqs_pkg::DATA_W-1:0]  result_value_o,
  output logic [dqs_pkg::POS_W-1:0]          position_o,
  output logic                               last_o
);
  import dqs_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int PW_W  = CNT_W + POS_W;

  function automatic logic [IDX_W-1:0] ring(input logic [IDX_W-1:0] base,
                                            input logic [CNT_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(off);
    if (sum >= SUM_W'(CAPACITY)) begin
      sum = sum - SUM_W'(CAPACITY);
    end
    return sum[IDX_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_of(input logic [CNT_W-1:0] off);
    logic [PW_W-1:0] p;
    p = PW_W'(off) + PW_W'(1);
    return p[POS_W-1:0];
  endfunction

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_q;
  logic [IDX_W-1:0]  rd_addr, wr_addr;
  logic              wr_en;

  logic [IDX_W-1:0]  front_q, front_d, front_dec, front_inc;
  logic [CNT_W-1:0]  count_q, count_d, count_m1;
  logic [CNT_W-1:0]  scan_q, scan_d, scan_nxt;
  logic [DATA_W-1:0] key_q, key_d;
  logic              pend_vld_q, pend_vld_d;
  logic [POS_W-1:0]  pend_pos_q, pend_pos_d;

  logic              out_vld_q, out_vld_d;
  logic [ST_W-1:0]   out_st_q, out_st_d;
  logic [DATA_W-1:0] out_val_q, out_val_d;
  logic [POS_W-1:0]  out_pos_q, out_pos_d;
  logic              out_last_q, out_last_d;

  logic empty, full, is_push, is_pop, match;

  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_W'(CAPACITY));
  assign is_push   = (opcode_i == OP_PUSH_FRONT) || (opcode_i == OP_PUSH_BACK);
  assign is_pop    = (opcode_i == OP_POP_FRONT) || (opcode_i == OP_POP_BACK);
  assign count_m1  = empty ? '0 : count_q - 1'b1;
  assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - 1'b1;
  assign front_inc = (front_q == IDX_W'(CAPACITY - 1)) ? '0 : front_q + 1'b1;
  assign scan_nxt  = scan_q + 1'b1;
  assign match     = (rd_q == key_q);

  assign stat_o.empty     = empty;
  assign stat_o.scan_last = (scan_nxt == count_q);

  // One read port: pop target on a transfer, next scan slot otherwise.
  always_comb begin
    if (cmd_i.accept) begin
      rd_addr = (opcode_i == OP_POP_BACK) ? ring(front_q, count_m1) : front_q;
    end else begin
      rd_addr = ring(front_q, scan_nxt);
    end
  end

  assign wr_en   = cmd_i.accept && is_push && !full;
  assign wr_addr = (opcode_i == OP_PUSH_FRONT) ? front_dec : ring(front_q, count_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= item_value_i;
    end
    rd_q <= mem[rd_addr];
  end

  always_comb begin
    front_d    = front_q;
    count_d    = count_q;
    scan_d     = scan_q;
    key_d      = key_q;
    pend_vld_d = pend_vld_q;
    pend_pos_d = pend_pos_q;
    out_vld_d  = 1'b0;
    out_st_d   = ST_OK;
    out_val_d  = '0;
    out_pos_d  = '0;
    out_last_d = 1'b1;

    priority if (cmd_i.accept) begin
      if (is_push) begin
        out_vld_d = 1'b1;
        if (full) begin
          out_st_d = ST_FULL;
        end else begin
          count_d = count_q + 1'b1;
          if (opcode_i == OP_PUSH_FRONT) begin
            front_d = front_dec;
          end
        end
      end else if (is_pop || (opcode_i == OP_SEARCH)) begin
        if (empty) begin
          out_vld_d = 1'b1;
          out_st_d  = ST_EMPTY;
        end else if (is_pop) begin
          count_d = count_m1;
          if (count_q == CNT_W'(1)) begin
            front_d = '0;
          end else if (opcode_i == OP_POP_FRONT) begin
            front_d = front_inc;
          end
        end else begin
          key_d      = item_value_i;
          scan_d     = '0;
          pend_vld_d = 1'b0;
        end
      end
    end else if (cmd_i.pop_emit) begin
      out_vld_d = 1'b1;
      out_val_d = rd_q;
    end else if (cmd_i.scan) begin
      // Hold each match until the next one shows it was not the final one.
      if (match) begin
        if (pend_vld_q) begin
          out_vld_d  = 1'b1;
          out_st_d   = ST_MATCH;
          out_val_d  = key_q;
          out_pos_d  = pend_pos_q;
          out_last_d = 1'b0;
        end
        pend_vld_d = 1'b1;
        pend_pos_d = pos_of(scan_q);
      end
      scan_d = scan_nxt;
    end else if (cmd_i.flush) begin
      out_vld_d = 1'b1;
      if (pend_vld_q) begin
        out_st_d  = ST_MATCH;
        out_val_d = key_q;
        out_pos_d = pend_pos_q;
      end else begin
        out_st_d = ST_NOT_FOUND;
      end
    end else begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q    <= '0;
      count_q    <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      front_q    <= front_d;
      count_q    <= count_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q     <= scan_d;
    key_q      <= key_d;
    pend_pos_q <= pend_pos_d;
    out_st_q   <= out_st_d;
    out_val_q  <= out_val_d;
    out_pos_q  <= out_pos_d;
    out_last_q <= out_last_d;
  end

  assign result_strobe_o = out_vld_q;
  assign status_o        = out_st_q;
  assign result_value_o  = out_val_q;
  assign position_o      = out_pos_q;
  assign last_o          = out_last_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAPACITY))
    else $error("held count exceeds capacity");

  a_front_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    SUM_W'(front_q) < SUM_W'(CAPACITY))
    else $error("front index outside the ring");

  a_empty_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (front_q == '0))
    else $error("empty queue with nonzero front index");

endmodule

FILE: bench/testbench.sv
// Self-checking bench for the double-ended queue with search: directed table, then random traffic.
// Predicts each result with its own ring model or takes it from a typed table row, and checks each strobe in order.
// Depends on dqs_pkg and double_ended_queue_with_search.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dqs_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 24;
  localparam int PHASE_ITEMS    = 63;
  localparam int POOL_SIZE      = 6;

  // Opcodes the block drops without a result.
  localparam logic [OP_W-1:0] OP_RSVD_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [ST_W-1:0]   status;
    logic [DATA_W-1:0] value;
    logic [POS_W-1:0]  pos;
    logic              last;
  } deque_result_t;

  // One row of the directed table; typed rows carry their expected result.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [DATA_W-1:0] val;
    logic [4:0]        rep;
    logic              typed;
    deque_result_t     exp;
  } stim_row_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     start_i;
  logic                     busy_o;
  logic [OP_W-1:0]          opcode_i;
  logic signed [DATA_W-1:0] item_value_i;
  logic                     result_strobe_o;
  logic [ST_W-1:0]          status_o;
  logic signed [DATA_W-1:0] result_value_o;
  logic [POS_W-1:0]         position_o;
  logic                     last_o;

  double_ended_queue_with_search u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .item_value_i   (item_value_i),
    .result_strobe_o(result_strobe_o),
    .status_o       (status_o),
    .result_value_o (result_value_o),
    .position_o     (position_o),
    .last_o         (last_o)
  );

  // Predicted deque contents, kept as a ring with front slot and count.
  logic [DATA_W-1:0] ring_slots [DQS_CAPACITY];
  int unsigned       head_slot;
  int unsigned       held_count;

  deque_result_t step_results [$];   // results of the command just taken
  deque_result_t results_due  [$];   // results still owed by the block, oldest first

  // Set by the driver at the falling edge that raises start_i.
  logic          row_typed;
  deque_result_t row_expect;

  logic [DATA_W-1:0] value_pool [POOL_SIZE];

  int            errors;
  int            quiet_cycles;
  logic          moved;
  deque_result_t got;
  deque_result_t want;

  initial clk_i = 1'b0;
  always #CLK_HALF clk_i = ~clk_i;

  function automatic deque_result_t result_of(input logic [ST_W-1:0] st,
                                              input logic [DATA_W-1:0] v,
                                              input logic [POS_W-1:0] p,
                                              input logic l);
    deque_result_t r;
    r.status = st;
    r.value  = v;
    r.pos    = p;
    r.last   = l;
    return r;
  endfunction

  // Apply one command to the predicted deque and append its results to step_results.
  function automatic void deque_apply(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val);
    int unsigned   slot;
    int unsigned   hits;
    deque_result_t r;
    case (op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (held_count >= DQS_CAPACITY) begin
          step_results.push_back(result_of(ST_FULL, '0, '0, 1'b1));
        end else begin
          if (op == OP_PUSH_FRONT) begin
            head_slot = (head_slot + DQS_CAPACITY - 1) % DQS_CAPACITY;
            ring_slots[head_slot] = val;
          end else begin
            ring_slots[(head_slot + held_count) % DQS_CAPACITY] = val;
          end
          held_count++;
          step_results.push_back(result_of(ST_OK, '0, '0, 1'b1));
        end
      end
      OP_POP_FRONT, OP_POP_BACK: begin
        if (held_count == 0) begin
          step_results.push_back(result_of(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          if (op == OP_POP_FRONT) begin
            step_results.push_back(result_of(ST_OK, ring_slots[head_slot], '0, 1'b1));
            head_slot = (head_slot + 1) % DQS_CAPACITY;
          end else begin
            slot = (head_slot + held_count - 1) % DQS_CAPACITY;
            step_results.push_back(result_of(ST_OK, ring_slots[slot], '0, 1'b1));
          end
          held_count--;
          // an emptied deque starts over at slot zero
          if (held_count == 0) head_slot = 0;
        end
      end
      OP_SEARCH: begin
        if (held_count == 0) begin
          step_results.push_back(result_of(ST_EMPTY, '0, '0, 1'b1));
        end else begin
          hits = 0;
          for (int unsigned i = 0; i < held_count; i++) begin
            slot = (head_slot + i) % DQS_CAPACITY;
            if (ring_slots[slot] == val) begin
              step_results.push_back(result_of(ST_MATCH, val, POS_W'(i + 1), 1'b0));
              hits++;
            end
          end
          if (hits == 0) begin
            step_results.push_back(result_of(ST_NOT_FOUND, '0, '0, 1'b1));
          end else begin
            // flag the final match as the last result of this search
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
          end
        end
      end
      default: ;  // reserved opcodes: no result, no change
    endcase
  endfunction

  // Checker and watchdog. Check results first: a result seen at this edge belongs to an
  // earlier transfer, never to the one taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      moved = 1'b0;
      if (result_strobe_o) begin
        moved = 1'b1;
        got = result_of(status_o, result_value_o, position_o, last_o);
        if (results_due.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d value %0h pos %0d last %0d",
                   $time, got.status, got.value, got.pos, got.last);
          errors++;
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status mismatch, expected %0d, actual %0d", $time, want.status,
                     got.status);
            errors++;
          end
          if (got.value !== want.value) begin
            $display("%0t: result_value mismatch, expected %0h, actual %0h", $time, want.value,
                     got.value);
            errors++;
          end
          if (got.pos !== want.pos) begin
            $display("%0t: position mismatch, expected %0d, actual %0d", $time, want.pos,
                     got.pos);
            errors++;
          end
          if (got.last !== want.last) begin
            $display("%0t: last mismatch, expected %0d, actual %0d", $time, want.last,
                     got.last);
            errors++;
          end
        end
      end
      // Command transfer: advance the prediction, then queue either the typed row or
      // the predicted results.
      if (start_i && !busy_o) begin
        moved = 1'b1;
        step_results.delete();
        deque_apply(opcode_i, item_value_i);
        if (row_typed) begin
          results_due.push_back(row_expect);
        end else begin
          foreach (step_results[i]) results_due.push_back(step_results[i]);
        end
      end
      if (moved) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("%0t: watchdog expired with %0d results outstanding", $time,
                   results_due.size());
          $display("** double_ended_queue_with_search: FAILED **");
          $finish;
        end
      end
    end
  end

  // Drive one command from the falling edge and hold it until the block takes it.
  // Idle cycles are inserted first, one at a time, with the given chance in percent.
  task automatic send_command(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] val,
                              input int idle_pct, input logic typed,
                              input deque_result_t exp);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    row_typed    = typed;
    row_expect   = exp;
    start_i      <= 1'b1;
    opcode_i     <= op;
    item_value_i <= val;
    do @(posedge clk_i); while (busy_o);
  endtask

  // Mostly values from a small pool so that searches hit, the rest fully random.
  function automatic logic [DATA_W-1:0] pick_value(input int pool_pct);
    logic [DATA_W-1:0] v;
    if ($urandom_range(0, 99) < pool_pct) v = value_pool[$urandom_range(0, POOL_SIZE - 1)];
    else v = $urandom;
    return v;
  endfunction

  stim_row_t dir_rows [16];

  initial begin
    int              idle_pct;
    int              taken;
    int              roll;
    logic            fill_bias;
    logic [OP_W-1:0] op;
    logic [DATA_W-1:0] val;

    errors       = 0;
    quiet_cycles = 0;
    head_slot    = 0;
    held_count   = 0;
    row_typed    = 1'b0;
    row_expect   = '0;
    start_i      = 1'b0;
    opcode_i     = OP_PUSH_FRONT;
    item_value_i = '0;
    rst_ni       = 1'b0;

    // Directed part: empty cases, extremes of the value range, a reserved opcode,
    // then fill to capacity with one value so a search returns a match per slot,
    // and push into the full deque from both ends.
    dir_rows = '{
      '{OP_POP_FRONT,  32'h0000_0000, 5'd1, 1'b1, '{ST_EMPTY,     32'h0,           5'd0, 1'b1}},
      '{OP_SEARCH,     32'h0000_0000, 5'd1, 1'b1, '{ST_EMPTY,     32'h0,           5'd0, 1'b1}},
      '{OP_PUSH_BACK,  32'h7fff_ffff, 5'd1, 1'b1, '{ST_OK,        32'h0,           5'd0, 1'b1}},
      '{OP_PUSH_FRONT, 32'h8000_0000, 5'd1, 1'b1, '{ST_OK,        32'h0,           5'd0, 1'b1}},
      '{OP_SEARCH,     32'h7fff_ffff, 5'd1, 1'b1, '{ST_MATCH,     32'h7fff_ffff,   5'd2, 1'b1}},
      '{OP_SEARCH,     32'h0000_0005, 5'd1, 1'b1, '{ST_NOT_FOUND, 32'h0,           5'd0, 1'b1}},
      '{OP_RSVD_5,     32'h0000_0000, 5'd1, 1'b0, '0},
      '{OP_POP_FRONT,  32'hffff_ffff, 5'd1, 1'b1, '{ST_OK,        32'h8000_0000,   5'd0, 1'b1}},
      '{OP_POP_BACK,   32'h0000_0000, 5'd1, 1'b1, '{ST_OK,        32'h7fff_ffff,   5'd0, 1'b1}},
      '{OP_POP_BACK,   32'h0000_0000, 5'd1, 1'b1, '{ST_EMPTY,     32'h0,           5'd0, 1'b1}},
      '{OP_PUSH_FRONT, 32'hffff_ffff, 5'd8, 1'b0, '0},
      '{OP_PUSH_BACK,  32'hffff_ffff, 5'd8, 1'b0, '0},
      '{OP_SEARCH,     32'hffff_ffff, 5'd1, 1'b0, '0},
      '{OP_PUSH_FRONT, 32'h0000_0001, 5'd1, 1'b1, '{ST_FULL,      32'h0,           5'd0, 1'b1}},
      '{OP_PUSH_BACK,  32'h0000_0002, 5'd1, 1'b1, '{ST_FULL,      32'h0,           5'd0, 1'b1}},
      '{OP_POP_BACK,   32'h0000_0000, 5'd1, 1'b1, '{ST_OK,        32'hffff_ffff,   5'd0, 1'b1}}
    };

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[r]) begin
      for (int k = 0; k < dir_rows[r].rep; k++) begin
        send_command(dir_rows[r].op, dir_rows[r].val, 14, dir_rows[r].typed, dir_rows[r].exp);
      end
    end

    // Random part in three phases: sender idle 14 %, then 76 %, then back to back.
    // Alternate fill-heavy and drain-heavy stretches so the deque reaches both full
    // and empty, and wraps around the ring.
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 14 : ((ph == 1) ? 76 : 0);
      foreach (value_pool[i]) value_pool[i] = $urandom;
      taken     = 0;
      fill_bias = 1'b1;
      while (taken < PHASE_ITEMS) begin
        if ($urandom_range(0, 24) == 0) fill_bias = ~fill_bias;
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          op  = OP_W'($urandom_range(OP_RSVD_5, OP_RSVD_7));
          val = $urandom;
        end else if (roll < 30) begin
          op  = OP_SEARCH;
          val = pick_value(80);
        end else if (roll < (fill_bias ? 85 : 45)) begin
          op  = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
          val = pick_value(70);
        end else begin
          op  = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
          val = $urandom;  // ignored by pops, still toggles every bit
        end
        send_command(op, val, idle_pct, 1'b0, '0);
        // dropped opcodes do not count toward the phase
        if (op <= OP_SEARCH) taken++;
      end
    end

    @(negedge clk_i);
    start_i <= 1'b0;

    // Drain: wait for every owed result, then a few more cycles for strays.
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("** double_ended_queue_with_search: PASSED **");
    end else begin
      $display("** double_ended_queue_with_search: FAILED **");
    end
    $finish;
  end

endmodule
